/* rtl/tlv_property_stream_validator_unit_assert.svh */
// ----------------------------------------------------------------------------
// tlv assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef TLV_PROPERTY_STREAM_VALIDATOR_UNIT_ASSERT_SVH
`define TLV_PROPERTY_STREAM_VALIDATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TLV_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tlv same-cycle check failed");

// next-cycle implication
`define TLV_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tlv next-cycle check failed");

`endif

/* rtl/tlv_pkg.sv */
// ----------------------------------------------------------------------------
// tlv_pkg
// shared types and codes of the tlv property stream validator
// ----------------------------------------------------------------------------
package tlv_pkg;

	// config port geometry: five 64-bit registers at 8-byte spacing
	localparam int unsigned ADDR_W = 6;
	localparam int unsigned DATA_W = 64;

	// register indexes
	localparam logic [2:0] REG_TYPES_0   = 3'd0;
	localparam logic [2:0] REG_TYPES_64  = 3'd1;
	localparam logic [2:0] REG_TYPES_128 = 3'd2;
	localparam logic [2:0] REG_TYPES_192 = 3'd3;
	localparam logic [2:0] REG_FINAL     = 3'd4;

	// byte kinds
	localparam logic [1:0] KIND_LIST_HDR = 2'd0;
	localparam logic [1:0] KIND_REC_HDR  = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD  = 2'd2;
	localparam logic [1:0] KIND_SKIP     = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FORMAT = 2'd1;
	localparam logic [1:0] ST_UNREG  = 2'd2;
	localparam logic [1:0] ST_SHORT  = 2'd3;

	// saturating blob byte counter
	localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

	typedef struct packed {
		logic [255:0] type_map;
		logic [7:0]   final_type;
	} tlv_cfg_t;

	typedef struct packed {
		logic [1:0]  byte_kind;
		logic [7:0]  prop_type;
		logic [7:0]  payload_value;
		logic [15:0] payload_offset;
		logic        last_of_prop;
		logic        done_res;
		logic [1:0]  status;
		logic        final_present;
	} tlv_result_t;

endpackage

/* rtl/tlv_cfg.sv */
// ----------------------------------------------------------------------------
// tlv_cfg
// apb register file: registered-type bitmap and final type code
// ----------------------------------------------------------------------------
module tlv_cfg
	import tlv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output tlv_cfg_t          cfg
);

	logic [63:0] types_q [4];
	logic [7:0]  final_type_q;
	logic [2:0]  reg_idx;
	logic        wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite && pready;

	// register writes, out-of-range indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			types_q[0]   <= '0;
			types_q[1]   <= '0;
			types_q[2]   <= '0;
			types_q[3]   <= '0;
			final_type_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TYPES_0:   types_q[0]   <= pwdata;
				REG_TYPES_64:  types_q[1]   <= pwdata;
				REG_TYPES_128: types_q[2]   <= pwdata;
				REG_TYPES_192: types_q[3]   <= pwdata;
				REG_FINAL:     final_type_q <= pwdata[7:0];
				default:       ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			REG_TYPES_0:   prdata = types_q[0];
			REG_TYPES_64:  prdata = types_q[1];
			REG_TYPES_128: prdata = types_q[2];
			REG_TYPES_192: prdata = types_q[3];
			REG_FINAL:     prdata = {56'd0, final_type_q};
			default:       prdata = '0;
		endcase
	end

	// type map first, final type code in the low byte
	assign cfg = {types_q[3], types_q[2], types_q[1], types_q[0], final_type_q};

endmodule

/* rtl/tlv_parser.sv */
// ----------------------------------------------------------------------------
// tlv_parser
// parse state and one-byte step: header decode, record checks, payload tags
// ----------------------------------------------------------------------------
`include "tlv_property_stream_validator_unit_assert.svh"

module tlv_parser
	import tlv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	input  tlv_cfg_t    cfg,
	output tlv_result_t res
);

	typedef enum logic [2:0] {
		PH_LEN_HI,
		PH_LEN_LO,
		PH_TYPE,
		PH_RLEN_HI,
		PH_RLEN_LO,
		PH_PAYLOAD,
		PH_SKIP
	} phase_t;

	phase_t      phase_q;
	logic [16:0] count_q;
	logic [15:0] len_q;
	logic [15:0] pos_q;
	logic [7:0]  type_q;
	logic [15:0] remain_q;
	logic [15:0] offset_q;
	logic [7:0]  len_hi_q;
	logic [1:0]  err_q;

	// state seen by this byte (cleared by first_byte)
	phase_t      ph_e;
	logic [16:0] cnt_e;
	logic [15:0] len_e, pos_e, remain_e, offset_e;
	logic [7:0]  type_e, len_hi_e;
	logic [1:0]  err_e;

	// next state
	phase_t      ph_n;
	logic [16:0] cnt_n;
	logic [15:0] len_n, pos_n, remain_n, offset_n;
	logic [7:0]  type_n, len_hi_n;
	logic [1:0]  err_n;

	logic [15:0] pos_inc;
	logic [15:0] rlen;
	logic [17:0] reach;
	logic [16:0] rem;
	logic        bnd_zero, bnd_short;
	logic [15:0] remain_dec;
	logic [16:0] len_plus2;
	logic        type_reg, final_reg;
	logic [1:0]  st;
	logic        restart_step;
	logic        kind_tagged;

	// effective state
	always_comb begin
		if (first_byte) begin
			ph_e     = PH_LEN_HI;
			cnt_e    = '0;
			len_e    = '0;
			pos_e    = '0;
			type_e   = '0;
			remain_e = '0;
			offset_e = '0;
			len_hi_e = '0;
			err_e    = ST_OK;
		end else begin
			ph_e     = phase_q;
			cnt_e    = count_q;
			len_e    = len_q;
			pos_e    = pos_q;
			type_e   = type_q;
			remain_e = remain_q;
			offset_e = offset_q;
			len_hi_e = len_hi_q;
			err_e    = err_q;
		end
	end

	// shared arithmetic for record checks
	assign pos_inc    = pos_e + 16'd1;
	assign rlen       = {len_hi_e, data_byte};
	assign reach      = {2'b00, pos_inc} + {2'b00, rlen};
	assign rem        = {1'b0, len_e} - {1'b0, pos_inc};
	assign bnd_zero   = (rem == 17'd0);
	assign bnd_short  = !rem[16] && (rem < 17'd3);
	assign remain_dec = remain_e - 16'd1;
	assign type_reg   = cfg.type_map[type_e];
	assign final_reg  = cfg.type_map[cfg.final_type];

	// one parse step
	always_comb begin
		ph_n     = ph_e;
		cnt_n    = (cnt_e == COUNT_MAX) ? cnt_e : cnt_e + 17'd1;
		len_n    = len_e;
		pos_n    = pos_e;
		type_n   = type_e;
		remain_n = remain_e;
		offset_n = offset_e;
		len_hi_n = len_hi_e;
		err_n    = err_e;

		res.byte_kind      = KIND_SKIP;
		res.prop_type      = '0;
		res.payload_value  = '0;
		res.payload_offset = '0;
		res.last_of_prop   = 1'b0;

		case (ph_e)
			PH_LEN_HI: begin
				res.byte_kind = KIND_LIST_HDR;
				len_hi_n      = data_byte;
				ph_n          = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				res.byte_kind = KIND_LIST_HDR;
				len_n         = {len_hi_e, data_byte};
				pos_n         = '0;
				if ({len_hi_e, data_byte} < 16'd3) begin
					err_n = (err_e == ST_OK) ? ST_FORMAT : err_e;
					ph_n  = PH_SKIP;
				end else begin
					ph_n = PH_TYPE;
				end
			end
			PH_TYPE: begin
				res.byte_kind = KIND_REC_HDR;
				res.prop_type = data_byte;
				type_n        = data_byte;
				pos_n         = pos_inc;
				ph_n          = PH_RLEN_HI;
			end
			PH_RLEN_HI: begin
				res.byte_kind = KIND_REC_HDR;
				res.prop_type = type_e;
				len_hi_n      = data_byte;
				pos_n         = pos_inc;
				ph_n          = PH_RLEN_LO;
			end
			PH_RLEN_LO: begin
				res.byte_kind = KIND_REC_HDR;
				res.prop_type = type_e;
				pos_n         = pos_inc;
				// overrun is checked ahead of registration
				if (reach > {2'b00, len_e}) begin
					err_n = (err_e == ST_OK) ? ST_FORMAT : err_e;
					ph_n  = PH_SKIP;
				end else if (!type_reg) begin
					err_n = (err_e == ST_OK) ? ST_UNREG : err_e;
					ph_n  = PH_SKIP;
				end else begin
					remain_n = rlen;
					offset_n = '0;
					if (rlen == 16'd0) begin
						res.last_of_prop = 1'b1;
						if (bnd_zero) begin
							ph_n = PH_SKIP;
						end else if (bnd_short) begin
							err_n = (err_e == ST_OK) ? ST_FORMAT : err_e;
							ph_n  = PH_SKIP;
						end else begin
							ph_n = PH_TYPE;
						end
					end else begin
						ph_n = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				res.byte_kind      = KIND_PAYLOAD;
				res.prop_type      = type_e;
				res.payload_value  = data_byte;
				res.payload_offset = offset_e;
				pos_n              = pos_inc;
				offset_n           = offset_e + 16'd1;
				remain_n           = remain_dec;
				if (remain_dec == 16'd0) begin
					res.last_of_prop = 1'b1;
					if (bnd_zero) begin
						ph_n = PH_SKIP;
					end else if (bnd_short) begin
						err_n = (err_e == ST_OK) ? ST_FORMAT : err_e;
						ph_n  = PH_SKIP;
					end else begin
						ph_n = PH_TYPE;
					end
				end
			end
			default: begin
				ph_n = PH_SKIP;
			end
		endcase

		// final status on the last byte
		len_plus2 = {1'b0, len_n} + 17'd2;
		st        = err_n;
		if (last_byte) begin
			if (cnt_n < 17'd2) begin
				st = ST_SHORT;
			end else if (cnt_n != len_plus2) begin
				st = ST_FORMAT;
			end
		end

		res.done_res      = last_byte;
		res.status        = st;
		res.final_present = last_byte && (st == ST_OK) && final_reg;
	end

	// state registers, cleared after the last byte of a blob
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEN_HI;
			count_q  <= '0;
			len_q    <= '0;
			pos_q    <= '0;
			type_q   <= '0;
			remain_q <= '0;
			offset_q <= '0;
			len_hi_q <= '0;
			err_q    <= ST_OK;
		end else if (step) begin
			if (last_byte) begin
				phase_q  <= PH_LEN_HI;
				count_q  <= '0;
				len_q    <= '0;
				pos_q    <= '0;
				type_q   <= '0;
				remain_q <= '0;
				offset_q <= '0;
				len_hi_q <= '0;
				err_q    <= ST_OK;
			end else begin
				phase_q  <= ph_n;
				count_q  <= cnt_n;
				len_q    <= len_n;
				pos_q    <= pos_n;
				type_q   <= type_n;
				remain_q <= remain_n;
				offset_q <= offset_n;
				len_hi_q <= len_hi_n;
				err_q    <= err_n;
			end
		end
	end

	// helpers for the checks below
	assign restart_step = step && (first_byte || last_byte);
	assign kind_tagged  = (res.byte_kind == KIND_REC_HDR) || (res.byte_kind == KIND_PAYLOAD);

	// first error sticks until the blob is restarted
	`TLV_ASSERT_NXT(a_err_sticky, err_q != ST_OK && !restart_step, err_q == $past(err_q))
	// once skipping, only a blob restart leaves the skip phase
	`TLV_ASSERT_NXT(a_skip_sticky, phase_q == PH_SKIP && !restart_step, phase_q == PH_SKIP)
	// a latched error always parks the parser in skip
	`TLV_ASSERT_IMP(a_err_skips, err_q != ST_OK, phase_q == PH_SKIP)
	// record end marks only on record header or payload bytes
	`TLV_ASSERT_IMP(a_lastp_kind, step && res.last_of_prop, kind_tagged)

endmodule

/* rtl/tlv_property_stream_validator_unit.sv */
// ----------------------------------------------------------------------------
// tlv_property_stream_validator_unit
// byte-serial validator for type-length-value property blobs
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | data_byte, first_byte, last_byte
//  out     | output    | out_valid/out_stall| byte_kind .. final_present
//  cfg     | input     | apb psel/penable   | paddr, pwdata, prdata
//
// one byte per cycle sustained while out_stall is low; a byte's result is
// registered: input register, then one parse step into the result register
// the parse step updates all parser state in the cycle it runs
// reset clears the parser and the type map; no clearing pass is needed
// out_stall holds the result register and backs up into the input register
// ----------------------------------------------------------------------------
module tlv_property_stream_validator_unit
	import tlv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// byte input
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              first_byte,
	input  logic              last_byte,
	// result output
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        byte_kind,
	output logic [7:0]        prop_type,
	output logic [7:0]        payload_value,
	output logic [15:0]       payload_offset,
	output logic              last_of_prop,
	output logic              done_res,
	output logic [1:0]        status,
	output logic              final_present,
	// config port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	tlv_cfg_t    cfg;
	tlv_result_t res;
	tlv_result_t res_s2;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       first_s1;
	logic       last_s1;
	logic       valid_s2;
	logic       adv_s2;
	logic       step;
	logic       accept;

	// pipeline control
	assign adv_s2   = !valid_s2 || !out_stall;
	assign step     = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;
	assign accept   = in_valid && !in_stall;

	tlv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tlv_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (data_s1),
		.first_byte (first_s1),
		.last_byte  (last_s1),
		.cfg        (cfg),
		.res        (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign byte_kind      = res_s2.byte_kind;
	assign prop_type      = res_s2.prop_type;
	assign payload_value  = res_s2.payload_value;
	assign payload_offset = res_s2.payload_offset;
	assign last_of_prop   = res_s2.last_of_prop;
	assign done_res       = res_s2.done_res;
	assign status         = res_s2.status;
	assign final_present  = res_s2.final_present;

endmodule
